// ===== hw/rtl/far_pkg.sv =====
// ----------------------------------------------------------------------------
// far_pkg
// shared types, register codes and port tables of the flow anomaly rule checker
// ----------------------------------------------------------------------------
`default_nettype none

package far_pkg;

    localparam int SEV_FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CFG_IDX_W         = 4;
    localparam int CFG_DATA_W        = 32;
    localparam int DIV_W             = 72;
    localparam logic [31:0] RST_MIN   = 32'd30;
    localparam logic [26:0] US_PER_S  = 27'd1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_SYN_MIN    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYN_RATIO  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ICMP_MIN   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ICMP_RATE  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUTE_MIN  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUTE_RATE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MIN   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RATE  = 4'd7;

    typedef struct packed {
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  ip_protocol;
        logic [31:0] syn_count;
        logic [31:0] ack_count;
        logic [31:0] rst_count;
        logic [31:0] fwd_packets;
        logic [31:0] bwd_packets;
        logic [39:0] duration_us;
    } t_in_item;

    typedef struct packed {
        logic [2:0] rule_id;
        logic [8:0] severity;
        logic       last_result;
    } t_out_item;

    typedef struct packed {
        logic [31:0] syn_min_count;
        logic [7:0]  syn_ack_ratio;
        logic [31:0] icmp_min_packets;
        logic [26:0] icmp_rate;
        logic [31:0] brute_min_packets;
        logic [26:0] brute_rate;
        logic [31:0] high_rate_min_packets;
        logic [26:0] high_rate;
    } t_cfg;

    typedef struct packed {
        logic        tcp;
        logic        icmp;
        logic        s_odd;
        logic        d_odd;
        logic        login;
        logic [32:0] total;
        logic [31:0] syn;
        logic [31:0] ack_a;
        logic [31:0] rst;
        logic [39:0] dur;
    } t_cls;

    typedef enum logic [2:0] {
        RULE_PORT  = 3'd0,
        RULE_SYN   = 3'd1,
        RULE_ICMP  = 3'd2,
        RULE_BRUTE = 3'd3,
        RULE_RATE  = 3'd4,
        RULE_RST   = 3'd5,
        RULE_NONE  = 3'd6
    } t_rule;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSC,
        ST_MRA,
        ST_RULE,
        ST_MLO,
        ST_MHI,
        ST_MSUM,
        ST_RCMP,
        ST_DSET,
        ST_DIV,
        ST_COMMIT,
        ST_FINAL
    } t_state;

    localparam logic [8:0] PROTO_TCP  = 9'd6;
    localparam logic [8:0] PROTO_ICMP = 9'd1;

    function automatic logic is_odd_port(input logic [15:0] p);
        logic r;
        case (p) inside
            16'd4444, 16'd5555, 16'd31337, 16'd1337, 16'd12345, 16'd54321,
            16'd6666, 16'd6667, 16'd6668, 16'd6669, 16'd8888, 16'd9999: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_login_port(input logic [15:0] p);
        logic r;
        case (p) inside
            16'd21, 16'd22, 16'd23, 16'd3389, 16'd5900: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/far_front.sv =====
// ----------------------------------------------------------------------------
// far_front
// accepts flow records, classifies them and queues them for the rule engine
// ----------------------------------------------------------------------------
`default_nettype none

module far_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire far_pkg::t_in_item i_item,
    output logic                   o_q_valid,
    input  wire logic              i_q_pop,
    output far_pkg::t_cls          o_q_item
);

    localparam int PW = $clog2(far_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(far_pkg::QUEUE_DEPTH + 1);

    far_pkg::t_cls r_mem [far_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    far_pkg::t_cls cls;
    logic push;

    always_comb begin
        cls.tcp   = ({1'b0, i_item.ip_protocol} == far_pkg::PROTO_TCP);
        cls.icmp  = ({1'b0, i_item.ip_protocol} == far_pkg::PROTO_ICMP);
        cls.s_odd = far_pkg::is_odd_port(i_item.source_port);
        cls.d_odd = far_pkg::is_odd_port(i_item.dest_port);
        cls.login = far_pkg::is_login_port(i_item.dest_port);
        cls.total = {1'b0, i_item.fwd_packets} + {1'b0, i_item.bwd_packets};
        cls.syn   = i_item.syn_count;
        cls.ack_a = (i_item.ack_count == 32'd0) ? 32'd1 : i_item.ack_count;
        cls.rst   = i_item.rst_count;
        cls.dur   = i_item.duration_us;
    end

    assign o_stall   = (r_cnt == CW'(far_pkg::QUEUE_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rp];

    always_comb begin
        n_wp  = push ? PW'(r_wp + 1'b1) : r_wp;
        n_rp  = i_q_pop ? PW'(r_rp + 1'b1) : r_rp;
        n_cnt = CW'(r_cnt + CW'(push) - CW'(i_q_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wp] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/far_back.sv =====
// ----------------------------------------------------------------------------
// far_back
// rule engine: shared multiplier, bit-serial severity divider, result output
// ----------------------------------------------------------------------------
`default_nettype none

module far_back #(
    parameter int SEVERITY_FRAC_BITS = far_pkg::SEV_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire far_pkg::t_cfg      i_cfg,
    input  wire logic               i_q_valid,
    output logic                    o_q_pop,
    input  wire far_pkg::t_cls      i_q_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output far_pkg::t_out_item      o_out
);

    localparam int F   = SEVERITY_FRAC_BITS;
    localparam int SW  = F + 1;
    localparam int CW  = $clog2(F);
    localparam int DW  = far_pkg::DIV_W;
    localparam int SEV_HI = ((1 << F) * 4) / 5;
    localparam int SEV_LO = ((1 << F) * 3) / 5;

    far_pkg::t_state r_state, n_state;
    far_pkg::t_rule  r_rule, n_rule, r_pend_id, n_pend_id;
    far_pkg::t_cls   r_rec, n_rec;
    far_pkg::t_out_item r_out, n_out;
    logic            r_out_v, n_out_v;
    logic            r_pend_v, n_pend_v;
    logic [SW-1:0]   r_pend_sev, n_pend_sev;
    logic [SW-1:0]   r_sev, n_sev;
    logic            r_fire, n_fire;
    logic [52:0]     r_scaled, n_scaled;
    logic [39:0]     r_ra, n_ra;
    logic [46:0]     r_plo, n_plo, r_phi, n_phi;
    logic [66:0]     r_prod, n_prod;
    logic [DW-1:0]   r_num, n_num, r_den, n_den;
    logic [DW:0]     r_rem, n_rem;
    logic [CW-1:0]   r_cnt, n_cnt;

    logic [32:0]     mul_a;
    logic [26:0]     mul_b;
    logic [59:0]     mul_p;
    logic [26:0]     thr;
    logic            rate_cond;
    logic            out_free;
    logic [DW:0]     shifted;
    logic [SW+8:0]   pend_wide;

    assign mul_p     = {27'd0, mul_a} * {33'd0, mul_b};
    assign out_free  = !r_out_v || !i_out_stall;
    assign shifted   = {r_rem[DW-1:0], 1'b0};
    assign pend_wide = {9'd0, r_pend_sev};

    always_comb begin
        case (r_rule)
            far_pkg::RULE_ICMP: begin
                thr = i_cfg.icmp_rate;
                rate_cond = r_rec.icmp && (r_rec.total >= {1'b0, i_cfg.icmp_min_packets});
            end
            far_pkg::RULE_BRUTE: begin
                thr = i_cfg.brute_rate;
                rate_cond = r_rec.tcp && r_rec.login &&
                            (r_rec.total >= {1'b0, i_cfg.brute_min_packets});
            end
            default: begin
                thr = i_cfg.high_rate;
                rate_cond = (r_rec.total >= {1'b0, i_cfg.high_rate_min_packets});
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_rule     = r_rule;
        n_rec      = r_rec;
        n_out      = r_out;
        n_out_v    = r_out_v && i_out_stall;
        n_pend_v   = r_pend_v;
        n_pend_id  = r_pend_id;
        n_pend_sev = r_pend_sev;
        n_sev      = r_sev;
        n_fire     = r_fire;
        n_scaled   = r_scaled;
        n_ra       = r_ra;
        n_plo      = r_plo;
        n_phi      = r_phi;
        n_prod     = r_prod;
        n_num      = r_num;
        n_den      = r_den;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        o_q_pop    = 1'b0;
        mul_a      = '0;
        mul_b      = '0;

        case (r_state)
            far_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_rec    = i_q_item;
                    n_pend_v = 1'b0;
                    n_state  = far_pkg::ST_MSC;
                end
            end
            far_pkg::ST_MSC: begin
                mul_a    = r_rec.total;
                mul_b    = far_pkg::US_PER_S;
                n_scaled = mul_p[52:0];
                n_state  = far_pkg::ST_MRA;
            end
            far_pkg::ST_MRA: begin
                mul_a   = {1'b0, r_rec.ack_a};
                mul_b   = {19'd0, i_cfg.syn_ack_ratio};
                n_ra    = mul_p[39:0];
                n_rule  = far_pkg::RULE_PORT;
                n_state = far_pkg::ST_RULE;
            end
            far_pkg::ST_RULE: begin
                case (r_rule)
                    far_pkg::RULE_PORT: begin
                        n_fire  = r_rec.s_odd || r_rec.d_odd;
                        n_sev   = (r_rec.s_odd && r_rec.d_odd) ? SW'(SEV_HI) : SW'(SEV_LO);
                        n_state = far_pkg::ST_COMMIT;
                    end
                    far_pkg::RULE_SYN: begin
                        n_fire  = r_rec.tcp && (r_rec.syn >= i_cfg.syn_min_count) &&
                                  ({8'd0, r_rec.syn} >= r_ra);
                        n_num   = DW'(r_rec.syn);
                        n_den   = DW'({r_ra, 2'b00});
                        n_state = far_pkg::ST_DSET;
                    end
                    far_pkg::RULE_ICMP, far_pkg::RULE_BRUTE, far_pkg::RULE_RATE: begin
                        if (rate_cond && (r_rec.dur != 40'd0)) begin
                            n_state = far_pkg::ST_MLO;
                        end else begin
                            n_fire  = 1'b0;
                            n_state = far_pkg::ST_COMMIT;
                        end
                    end
                    far_pkg::RULE_RST: begin
                        n_fire  = r_rec.tcp && (r_rec.rst >= far_pkg::RST_MIN) &&
                                  (r_rec.total != 33'd0) &&
                                  ({r_rec.rst, 1'b0} >= r_rec.total);
                        n_num   = DW'(r_rec.rst);
                        n_den   = DW'(r_rec.total);
                        n_state = far_pkg::ST_DSET;
                    end
                    default: begin
                        n_state = far_pkg::ST_FINAL;
                    end
                endcase
            end
            far_pkg::ST_MLO: begin
                mul_a   = {6'd0, thr};
                mul_b   = {7'd0, r_rec.dur[19:0]};
                n_plo   = mul_p[46:0];
                n_state = far_pkg::ST_MHI;
            end
            far_pkg::ST_MHI: begin
                mul_a   = {6'd0, thr};
                mul_b   = {7'd0, r_rec.dur[39:20]};
                n_phi   = mul_p[46:0];
                n_state = far_pkg::ST_MSUM;
            end
            far_pkg::ST_MSUM: begin
                n_prod  = {20'd0, r_plo} + {r_phi, 20'd0};
                n_state = far_pkg::ST_RCMP;
            end
            far_pkg::ST_RCMP: begin
                n_fire = ({14'd0, r_scaled} >= r_prod);
                n_num  = DW'(r_scaled);
                if (r_rule == far_pkg::RULE_RATE) begin
                    n_den = {3'd0, r_prod, 2'b00} + {5'd0, r_prod};
                end else begin
                    n_den = {2'd0, r_prod, 3'b000} + {4'd0, r_prod, 1'b0};
                end
                n_state = far_pkg::ST_DSET;
            end
            far_pkg::ST_DSET: begin
                if (!r_fire) begin
                    n_state = far_pkg::ST_COMMIT;
                end else if ((r_den == '0) || (r_num >= r_den)) begin
                    n_sev   = SW'(1 << F);
                    n_state = far_pkg::ST_COMMIT;
                end else begin
                    n_sev   = '0;
                    n_rem   = {1'b0, r_num};
                    n_cnt   = '0;
                    n_state = far_pkg::ST_DIV;
                end
            end
            far_pkg::ST_DIV: begin
                if (shifted >= {1'b0, r_den}) begin
                    n_rem = shifted - {1'b0, r_den};
                    n_sev = {r_sev[SW-2:0], 1'b1};
                end else begin
                    n_rem = shifted;
                    n_sev = {r_sev[SW-2:0], 1'b0};
                end
                n_cnt = CW'(r_cnt + 1'b1);
                if (r_cnt == CW'(F - 1)) begin
                    n_state = far_pkg::ST_COMMIT;
                end
            end
            far_pkg::ST_COMMIT: begin
                if (!r_fire || !r_pend_v || out_free) begin
                    if (r_fire) begin
                        if (r_pend_v) begin
                            n_out.rule_id     = r_pend_id;
                            n_out.severity    = pend_wide[8:0];
                            n_out.last_result = 1'b0;
                            n_out_v           = 1'b1;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_id  = r_rule;
                        n_pend_sev = r_sev;
                    end
                    if (r_rule == far_pkg::RULE_RST) begin
                        n_state = far_pkg::ST_FINAL;
                    end else begin
                        n_rule  = far_pkg::t_rule'(r_rule + 3'd1);
                        n_state = far_pkg::ST_RULE;
                    end
                end
            end
            far_pkg::ST_FINAL: begin
                if (out_free) begin
                    if (r_pend_v) begin
                        n_out.rule_id  = r_pend_id;
                        n_out.severity = pend_wide[8:0];
                    end else begin
                        n_out.rule_id  = far_pkg::RULE_NONE;
                        n_out.severity = 9'd0;
                    end
                    n_out.last_result = 1'b1;
                    n_out_v  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = far_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = far_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= far_pkg::ST_IDLE;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_rule   <= far_pkg::RULE_PORT;
        end else begin
            r_state  <= n_state;
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
            r_rule   <= n_rule;
        end
        r_rec      <= n_rec;
        r_out      <= n_out;
        r_pend_id  <= n_pend_id;
        r_pend_sev <= n_pend_sev;
        r_sev      <= n_sev;
        r_fire     <= n_fire;
        r_scaled   <= n_scaled;
        r_ra       <= n_ra;
        r_plo      <= n_plo;
        r_phi      <= n_phi;
        r_prod     <= n_prod;
        r_num      <= n_num;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == far_pkg::ST_DIV |-> r_cnt <= CW'(F - 1))
        else $error("divider step count overrun");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == far_pkg::ST_FINAL && out_free |=> !r_pend_v && r_out_v &&
        r_out.last_result && r_state == far_pkg::ST_IDLE)
        else $error("flow not closed with a last item");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.rule_id == far_pkg::RULE_NONE |->
        r_out.last_result && r_out.severity == 9'd0)
        else $error("none item malformed");

endmodule

`default_nettype wire

// ===== hw/rtl/flow_anomaly_rule_checker.sv =====
// ----------------------------------------------------------------------------
// flow_anomaly_rule_checker
// checks six anomaly rules on each finished flow record and emits results
// ----------------------------------------------------------------------------
// Each flow record yields one result item per rule that fires (port, SYN
// flood, ICMP flood, brute force, high rate, reset flood, in that order),
// the final one flagged last, or a single "none" item. A two-entry queue
// takes records while the rule engine works. The engine runs the rules one
// after another on one shared multiplier and a bit-serial divider that
// works out the severity fraction of a fired rule bit by bit. ICMP flood
// and brute force exclude each other, so a record fires at most five rules,
// and an output stall holds the engine.
// Configuration writes are taken in any cycle and should be made idle.
`default_nettype none

module flow_anomaly_rule_checker #(
    parameter int SEVERITY_FRAC_BITS = far_pkg::SEV_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire far_pkg::t_in_item                 i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output far_pkg::t_out_item                     o_out_item,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [far_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [far_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    far_pkg::t_cfg r_cfg, n_cfg;
    far_pkg::t_cls q_item;
    logic          q_valid, q_pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                far_pkg::CFG_SYN_MIN:    n_cfg.syn_min_count         = i_cfg_data;
                far_pkg::CFG_SYN_RATIO:  n_cfg.syn_ack_ratio         = i_cfg_data[7:0];
                far_pkg::CFG_ICMP_MIN:   n_cfg.icmp_min_packets      = i_cfg_data;
                far_pkg::CFG_ICMP_RATE:  n_cfg.icmp_rate             = i_cfg_data[26:0];
                far_pkg::CFG_BRUTE_MIN:  n_cfg.brute_min_packets     = i_cfg_data;
                far_pkg::CFG_BRUTE_RATE: n_cfg.brute_rate            = i_cfg_data[26:0];
                far_pkg::CFG_HIGH_MIN:   n_cfg.high_rate_min_packets = i_cfg_data;
                far_pkg::CFG_HIGH_RATE:  n_cfg.high_rate             = i_cfg_data[26:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.syn_min_count         <= 32'd50;
            r_cfg.syn_ack_ratio         <= 8'd5;
            r_cfg.icmp_min_packets      <= 32'd20;
            r_cfg.icmp_rate             <= 27'd100;
            r_cfg.brute_min_packets     <= 32'd20;
            r_cfg.brute_rate            <= 27'd10;
            r_cfg.high_rate_min_packets <= 32'd100;
            r_cfg.high_rate             <= 27'd10000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    far_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (i_in_item),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_item  (q_item)
    );

    far_back #(
        .SEVERITY_FRAC_BITS (SEVERITY_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_item    (q_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out_item)
    );

endmodule

`default_nettype wire
